// ===== rtl/core/pdm_pkg.sv =====
// Shared types and constants for the Pareto dominance marker.
`default_nettype none

package pdm_pkg;

  localparam int unsigned CostW = 32;
  localparam int unsigned IndexW = 6;

  typedef struct packed {
    logic signed [CostW-1:0] cost_a;
    logic signed [CostW-1:0] cost_b;
    logic signed [CostW-1:0] cost_c;
    logic                    last_particle;
  } in_t;

  typedef struct packed {
    logic [IndexW-1:0] particle_index;
    logic              dominated;
    logic              overflow;
    logic              last_result;
  } out_t;

  typedef struct packed {
    logic signed [CostW-1:0] a;
    logic signed [CostW-1:0] b;
    logic signed [CostW-1:0] c;
  } cost_set_t;

  typedef struct packed {
    logic              load;
    logic [IndexW-1:0] particle_index;
    logic              overflow;
    logic              last_result;
  } res_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdm_lane.sv =====
// One comparison lane that holds a stored candidate and tests whether it covers another.
`default_nettype none

module pdm_lane #(
  parameter int unsigned PopSize = 32,
  parameter int unsigned NumObj  = 3,
  parameter int unsigned LaneIdx = 0
) (
  input  wire                       clk_i,
  input  wire                       wr_en_i,
  input  wire pdm_pkg::cost_set_t   wr_cost_i,
  input  wire                       active_i,
  input  wire pdm_pkg::cost_set_t   cand_cost_i,
  input  wire [$clog2(PopSize)-1:0] cand_idx_i,
  output logic                      hit_o
);

  localparam int unsigned IdxW = $clog2(PopSize);

  pdm_pkg::cost_set_t cost_q;
  logic               le_a;
  logic               le_b;
  logic               le_c;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      cost_q <= wr_cost_i;
    end
  end

  assign le_a = cost_q.a <= cand_cost_i.a;
  assign le_b = (NumObj < 2) || (cost_q.b <= cand_cost_i.b);
  assign le_c = (NumObj < 3) || (cost_q.c <= cand_cost_i.c);

  assign hit_o = active_i && (cand_idx_i != IdxW'(LaneIdx)) && le_a && le_b && le_c;

endmodule

`default_nettype wire

// ===== rtl/core/pdm_merge.sv =====
// Merging stage that combines lane hits into a flag and holds the result register.
`default_nettype none

module pdm_merge #(
  parameter int unsigned PopSize = 32
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire [PopSize-1:0]      hits_i,
  input  wire pdm_pkg::res_ctl_t ctl_i,
  input  wire                    out_stall_i,
  output logic                   out_valid_o,
  output pdm_pkg::out_t          out_data_o
);

  logic          valid_q;
  logic          valid_d;
  pdm_pkg::out_t data_q;

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.load) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q.particle_index <= ctl_i.particle_index;
      data_q.dominated      <= |hits_i;
      data_q.overflow       <= ctl_i.overflow;
      data_q.last_result    <= ctl_i.last_result;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/pareto_dominance_marker_core.sv =====
// Top level of the Pareto dominance marker with load control, cost memory and lanes.
// Loading takes one candidate per cycle with no result until the last one arrives.
// After the last candidate, each stored candidate passes three steps: a cost memory
// read, one parallel compare against all lanes, and the result register, which keeps
// each result until accepted. The first result follows the read and compare states.
// Reset clears the stored count, the overflow flag and the result valid flag.
`default_nettype none

module pareto_dominance_marker_core #(
  parameter int unsigned POP_SIZE       = 32,
  parameter int unsigned NUM_OBJECTIVES = 3
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire pdm_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output pdm_pkg::out_t      out_data_o
);

  localparam int unsigned IdxW = $clog2(POP_SIZE);
  localparam int unsigned CntW = $clog2(POP_SIZE + 1);

  typedef enum logic [3:0] {
    StLoad = 4'b0001,
    StRead = 4'b0010,
    StCmp  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  state_e             state_q;
  state_e             state_d;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    count_d;
  logic [IdxW-1:0]    idx_q;
  logic [IdxW-1:0]    idx_d;
  logic               ovf_q;
  logic               ovf_d;
  logic               in_acc;
  logic               out_acc;
  logic               full;
  logic               store;
  logic               last_res;
  pdm_pkg::cost_set_t wr_cost;
  pdm_pkg::cost_set_t rd_cost_q;
  pdm_pkg::cost_set_t mem [POP_SIZE];
  logic [POP_SIZE-1:0] hits;
  pdm_pkg::res_ctl_t  res_ctl;

  assign in_stall_o = (state_q != StLoad);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign full       = (count_q == CntW'(POP_SIZE));
  assign store      = in_acc && !full;
  assign last_res   = ((CntW'(idx_q) + CntW'(1)) == count_q);

  assign wr_cost.a = in_data_i.cost_a;
  assign wr_cost.b = in_data_i.cost_b;
  assign wr_cost.c = in_data_i.cost_c;

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[count_q[IdxW-1:0]] <= wr_cost;
    end
    if (state_q == StRead) begin
      rd_cost_q <= mem[idx_q];
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (in_data_i.last_particle) begin
            idx_d   = '0;
            state_d = StRead;
          end
        end
      end
      StRead: begin
        state_d = StCmp;
      end
      StCmp: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_acc) begin
          if (last_res) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = StLoad;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = StRead;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      count_q <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
    end
  end

  for (genvar g = 0; g < POP_SIZE; g++) begin : g_lane
    pdm_lane #(
      .PopSize(POP_SIZE),
      .NumObj (NUM_OBJECTIVES),
      .LaneIdx(g)
    ) u_lane (
      .clk_i      (clk_i),
      .wr_en_i    (store && (count_q[IdxW-1:0] == IdxW'(g))),
      .wr_cost_i  (wr_cost),
      .active_i   (CntW'(g) < count_q),
      .cand_cost_i(rd_cost_q),
      .cand_idx_i (idx_q),
      .hit_o      (hits[g])
    );
  end

  assign res_ctl.load           = (state_q == StCmp);
  assign res_ctl.particle_index = pdm_pkg::IndexW'(idx_q);
  assign res_ctl.overflow       = ovf_q;
  assign res_ctl.last_result    = last_res;

  pdm_merge #(
    .PopSize(POP_SIZE)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hits_i     (hits),
    .ctl_i      (res_ctl),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(POP_SIZE))
    else $error("Stored count exceeds capacity.");

  a_out_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == StOut))
    else $error("Result shown outside the output state.");

  a_last_starts_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last_particle) |=> (state_q == StRead) && (idx_q == '0))
    else $error("Last transaction did not start evaluation.");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CntW'(idx_q) < count_q))
    else $error("Result index beyond stored count.");

endmodule

`default_nettype wire
